FILE: rtl/yaz0d_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the yaz0 stream decompressor
// no dependencies; imported by front, command queue, back and top level
package yaz0d_pkg;

    localparam int HEADER_LEN = 16;
    localparam int LANE_BYTES = 8;
    localparam int HIST_AW    = 12;
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_PASSTHROUGH = 2'd1,
        ST_TRUNCATED   = 2'd2,
        ST_DIST_ERROR  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_RAW  = 2'd1,
        CMD_LIT  = 2'd2,
        CMD_COPY = 2'd3
    } cmd_kind_t;

    // one classified input beat, as handed from front to back
    typedef struct packed {
        cmd_kind_t           kind;
        logic [2:0]          magic_n;
        logic                has_b;
        logic [7:0]          b;
        logic [8:0]          len;
        logic [8:0]          zero_n;
        logic [HIST_AW-1:0]  distance;
        status_t             status;
        logic                ended;
        logic                last;
    } cmd_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] i);
        logic [7:0] r;
        r = 8'h00;
        unique case (i)
            2'd0: r = 8'h59;
            2'd1: r = 8'h61;
            2'd2: r = 8'h7A;
            2'd3: r = 8'h30;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/yaz0d_front.sv
`timescale 1ns / 1ps
// header and token parser: turns input beats into at most one back-end command each
// depends on yaz0d_pkg
module yaz0d_front
    import yaz0d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       cmd_push,
    output cmd_t       cmd
);

    logic [4:0]  hidx_reg, hidx_next;
    logic [31:0] tgt_reg, tgt_next;
    logic [31:0] prod_reg, prod_next;
    logic [7:0]  flag_reg, flag_next;
    logic [3:0]  fleft_reg, fleft_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  pfirst_reg, pfirst_next;
    logic [11:0] pdist_reg, pdist_next;
    logic        pt_reg, pt_next;

    // copy arithmetic, shared by short and long matches
    logic [11:0] c_dist;
    logic [8:0]  c_len;
    logic [31:0] c_rem;
    logic [8:0]  c_eff;
    logic [12:0] c_dist1;
    logic        c_err;
    logic [12:0] c_zn;
    logic [8:0]  c_zero;
    logic [8:0]  nbytes;

    always_comb
    begin
        if (phase_reg == 2'd1)
        begin
            c_dist = {pfirst_reg[3:0], in_byte};
            c_len  = {5'd0, pfirst_reg[7:4]} + 9'd2;
        end
        else
        begin
            c_dist = pdist_reg;
            c_len  = {1'b0, in_byte} + 9'd18;
        end
        c_rem   = tgt_reg - prod_reg;
        c_eff   = (c_rem < {23'd0, c_len}) ? c_rem[8:0] : c_len;
        c_dist1 = {1'b0, c_dist} + 13'd1;
        c_err   = prod_reg < {19'd0, c_dist1};
        c_zn    = c_dist1 - prod_reg[12:0];
        if (!c_err)
            c_zero = 9'd0;
        else if (c_zn < {4'd0, c_eff})
            c_zero = c_zn[8:0];
        else
            c_zero = c_eff;
    end

    always_comb
    begin
        hidx_next   = hidx_reg;
        tgt_next    = tgt_reg;
        prod_next   = prod_reg;
        flag_next   = flag_reg;
        fleft_next  = fleft_reg;
        phase_next  = phase_reg;
        pfirst_next = pfirst_reg;
        pdist_next  = pdist_reg;
        pt_next     = pt_reg;
        cmd         = '0;
        cmd.kind    = CMD_NONE;
        cmd.status  = ST_OK;
        cmd.b       = in_byte;
        cmd.last    = in_last;
        cmd_push    = 1'b0;
        nbytes      = 9'd0;

        if (accept)
        begin
            if (pt_reg)
            begin
                cmd.kind   = CMD_RAW;
                cmd.has_b  = 1'b1;
                cmd.status = ST_PASSTHROUGH;
                cmd.ended  = in_last;
                cmd_push   = 1'b1;
            end
            else if (hidx_reg < 5'(HEADER_LEN))
            begin
                if (hidx_reg < 5'd4)
                begin
                    if (in_byte != magic_byte(hidx_reg[1:0]))
                    begin
                        cmd.kind    = CMD_RAW;
                        cmd.magic_n = hidx_reg[2:0];
                        cmd.has_b   = 1'b1;
                        cmd.status  = ST_PASSTHROUGH;
                        cmd.ended   = in_last;
                        cmd_push    = 1'b1;
                        pt_next     = 1'b1;
                    end
                    else
                    begin
                        hidx_next = hidx_reg + 5'd1;
                        if (in_last)
                        begin
                            cmd_push  = 1'b1;
                            cmd.ended = 1'b1;
                            if (hidx_next < 5'd4)
                            begin
                                cmd.kind    = CMD_RAW;
                                cmd.magic_n = hidx_next[2:0];
                                cmd.status  = ST_PASSTHROUGH;
                            end
                            else
                                cmd.status = ST_TRUNCATED;
                        end
                    end
                end
                else
                begin
                    if (hidx_reg < 5'd8)
                        tgt_next = {tgt_reg[23:0], in_byte};
                    hidx_next = hidx_reg + 5'd1;
                    if (hidx_next == 5'(HEADER_LEN) && tgt_next == 32'd0)
                    begin
                        cmd.ended = 1'b1;
                        cmd_push  = 1'b1;
                    end
                    else if (in_last)
                    begin
                        cmd.ended  = 1'b1;
                        cmd.status = ST_TRUNCATED;
                        cmd_push   = 1'b1;
                    end
                end
            end
            else if (prod_reg >= tgt_reg)
            begin
                // output already complete: swallow, only pass the end mark along
                cmd_push = in_last;
            end
            else
            begin
                if (phase_reg == 2'd0 && fleft_reg == 4'd0)
                begin
                    flag_next  = in_byte;
                    fleft_next = 4'd8;
                end
                else if (phase_reg == 2'd0)
                begin
                    if (flag_reg[7])
                    begin
                        cmd.kind   = CMD_LIT;
                        nbytes     = 9'd1;
                        flag_next  = {flag_reg[6:0], 1'b0};
                        fleft_next = fleft_reg - 4'd1;
                    end
                    else
                    begin
                        pfirst_next = in_byte;
                        phase_next  = 2'd1;
                    end
                end
                else if (phase_reg == 2'd1 && pfirst_reg[7:4] == 4'd0)
                begin
                    pdist_next = c_dist;
                    phase_next = 2'd2;
                end
                else
                begin
                    cmd.kind     = CMD_COPY;
                    cmd.len      = c_eff;
                    cmd.zero_n   = c_zero;
                    cmd.distance = c_dist;
                    nbytes       = c_eff;
                    flag_next    = {flag_reg[6:0], 1'b0};
                    fleft_next   = (fleft_reg != 4'd0) ? fleft_reg - 4'd1 : 4'd0;
                    phase_next   = 2'd0;
                end
                prod_next = prod_reg + {23'd0, nbytes};
                if (prod_next >= tgt_reg)
                    cmd.ended = 1'b1;
                else if (in_last)
                begin
                    cmd.ended  = 1'b1;
                    cmd.status = ST_TRUNCATED;
                end
                if (cmd.kind == CMD_COPY && c_zero != 9'd0)
                    cmd.status = ST_DIST_ERROR;
                cmd_push = (nbytes != 9'd0) || cmd.ended || in_last;
            end

            if (in_last)
            begin
                hidx_next   = '0;
                tgt_next    = '0;
                prod_next   = '0;
                flag_next   = '0;
                fleft_next  = '0;
                phase_next  = '0;
                pfirst_next = '0;
                pdist_next  = '0;
                pt_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hidx_reg   <= '0;
            tgt_reg    <= '0;
            prod_reg   <= '0;
            flag_reg   <= '0;
            fleft_reg  <= '0;
            phase_reg  <= '0;
            pfirst_reg <= '0;
            pdist_reg  <= '0;
            pt_reg     <= 1'b0;
        end
        else
        begin
            hidx_reg   <= hidx_next;
            tgt_reg    <= tgt_next;
            prod_reg   <= prod_next;
            flag_reg   <= flag_next;
            fleft_reg  <= fleft_next;
            phase_reg  <= phase_next;
            pfirst_reg <= pfirst_next;
            pdist_reg  <= pdist_next;
            pt_reg     <= pt_next;
        end
    end

endmodule

FILE: rtl/yaz0d_cmdq.sv
`timescale 1ns / 1ps
// small command queue between parser and copy engine
// depends on yaz0d_pkg
module yaz0d_cmdq
    import yaz0d_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output logic empty,
    output cmd_t rd_cmd
);

    cmd_t               entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wptr_reg, rptr_reg;
    logic [CMDQ_AW:0]   cnt_reg;

    assign full   = cnt_reg == (CMDQ_AW+1)'(CMDQ_DEPTH);
    assign empty  = cnt_reg == '0;
    assign rd_cmd = entry_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wptr_reg <= wptr_reg + 1'b1;
            if (rd_en)
                rptr_reg <= rptr_reg + 1'b1;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/yaz0d_back.sv
`timescale 1ns / 1ps
// copy engine: runs commands byte by byte over the 4 KB history and packs result lanes
// depends on yaz0d_pkg
module yaz0d_back
    import yaz0d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    input  logic       pop,
    output logic       out_valid,
    output logic [7:0] out_lane [LANE_BYTES],
    output logic [3:0] out_count,
    output status_t    out_status,
    output logic       out_done,
    output logic       out_run_last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BYTE = 3'b010,
        S_MEM  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cur_reg;
    logic [8:0]         idx_reg, total_reg;
    logic [2:0]         lcnt_reg;
    logic [7:0]         lane_reg [LANE_BYTES];
    logic [HIST_AW-1:0] hptr_reg, hptr_next;
    logic [7:0]         hist_mem [1 << HIST_AW];
    logic [7:0]         rdata_reg;
    logic               rd_en;
    logic [HIST_AW-1:0] rd_addr;

    logic       out_free, out_load, emit_empty;
    logic       put_req, put_go, put_final, put_flush;
    logic [7:0] put_val, direct_val;
    logic       need_mem, finish;

    assign out_free = !out_valid || pop;
    assign need_mem = (cur_reg.kind == CMD_COPY) && (idx_reg >= cur_reg.zero_n);
    assign rd_addr  = hptr_reg - cur_reg.distance - HIST_AW'(1);

    always_comb
    begin
        if (cur_reg.kind == CMD_RAW && idx_reg < {6'd0, cur_reg.magic_n})
            direct_val = magic_byte(idx_reg[1:0]);
        else if (cur_reg.kind == CMD_COPY)
            direct_val = 8'h00;
        else
            direct_val = cur_reg.b;
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        put_req    = 1'b0;
        put_val    = direct_val;
        emit_empty = 1'b0;
        finish     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = S_BYTE;
                end
            end
            S_BYTE:
            begin
                if (total_reg == 9'd0)
                begin
                    if (!cur_reg.ended)
                        finish = 1'b1;
                    else if (out_free)
                    begin
                        emit_empty = 1'b1;
                        finish     = 1'b1;
                    end
                end
                else if (need_mem)
                begin
                    rd_en      = 1'b1;
                    state_next = S_MEM;
                end
                else
                    put_req = 1'b1;
            end
            S_MEM:
            begin
                put_req = 1'b1;
                put_val = rdata_reg;
            end
            default: state_next = S_IDLE;
        endcase

        put_final = idx_reg + 9'd1 == total_reg;
        put_flush = put_final || lcnt_reg == 3'(LANE_BYTES - 1);
        put_go    = put_req && (!put_flush || out_free);
        if (put_go)
            state_next = put_final ? S_IDLE : S_BYTE;
        if (put_go && put_final)
            finish = 1'b1;
        if (finish)
            state_next = S_IDLE;

        hptr_next = hptr_reg;
        if (put_go && cur_reg.kind != CMD_RAW)
            hptr_next = hptr_reg + HIST_AW'(1);
        if (finish && cur_reg.last)
            hptr_next = '0;
        out_load = emit_empty || (put_go && put_flush);
    end

    always_ff @(posedge clk)
    begin
        if (put_go && cur_reg.kind != CMD_RAW)
            hist_mem[hptr_reg] <= put_val;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= hist_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_cmd;
        if (put_go && !put_flush)
            lane_reg[lcnt_reg] <= put_val;
        if (out_load)
        begin
            for (int j = 0; j < LANE_BYTES; j++)
            begin
                if (emit_empty || j > int'(lcnt_reg))
                    out_lane[j] <= 8'h00;
                else if (j == int'(lcnt_reg))
                    out_lane[j] <= put_val;
                else
                    out_lane[j] <= lane_reg[j];
            end
            out_count    <= emit_empty ? 4'd0 : {1'b0, lcnt_reg} + 4'd1;
            out_status   <= cur_reg.status;
            out_run_last <= emit_empty || put_final;
            out_done     <= cur_reg.ended && (emit_empty || put_final);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            total_reg <= '0;
            lcnt_reg  <= '0;
            hptr_reg  <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hptr_reg  <= hptr_next;
            if (q_pop)
            begin
                idx_reg <= '0;
                lcnt_reg <= '0;
                unique case (q_cmd.kind)
                    CMD_RAW:  total_reg <= {6'd0, q_cmd.magic_n} + {8'd0, q_cmd.has_b};
                    CMD_LIT:  total_reg <= 9'd1;
                    CMD_COPY: total_reg <= q_cmd.len;
                    default:  total_reg <= 9'd0;
                endcase
            end
            else if (put_go)
            begin
                idx_reg  <= idx_reg + 9'd1;
                lcnt_reg <= put_flush ? 3'd0 : lcnt_reg + 3'd1;
            end
            if (out_load)
                out_valid <= 1'b1;
            else if (pop)
                out_valid <= 1'b0;
        end
    end

endmodule

FILE: rtl/yaz0_stream_decompressor_core.sv
`timescale 1ns / 1ps
// Yaz0 stream decompressor. A compressed file goes in one byte per beat on the push side;
// decompressed bytes come out up to eight per beat, with count, status, end-of-stream and
// last-of-this-input marks. The parser takes one input byte per cycle as long as its
// four-entry command queue has room. The copy engine takes a command only when idle,
// then passes literal, zero-fill and passthrough bytes straight on, while each byte copied
// from the 4 KB history goes through a registered memory read, then the write-back; long
// matches fill the queue and hold off input. A result stalled at the output holds the
// engine only when it would finish another result. The history needs no clearing after
// reset.
// depends on yaz0d_pkg, yaz0d_front, yaz0d_cmdq, yaz0d_back
module yaz0_stream_decompressor_core
    import yaz0d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte_0,
    output logic [7:0] out_byte_1,
    output logic [7:0] out_byte_2,
    output logic [7:0] out_byte_3,
    output logic [7:0] out_byte_4,
    output logic [7:0] out_byte_5,
    output logic [7:0] out_byte_6,
    output logic [7:0] out_byte_7,
    output logic [3:0] byte_count,
    output logic [1:0] status,
    output logic       stream_done,
    output logic       run_last
);

    logic       accept, cmd_push, q_empty, q_pop, out_valid;
    cmd_t       cmd, q_cmd;
    logic [7:0] lane [LANE_BYTES];
    status_t    out_status;

    assign accept = push && !full;

    yaz0d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    yaz0d_cmdq u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (cmd),
        .full   (full),
        .rd_en  (q_pop),
        .empty  (q_empty),
        .rd_cmd (q_cmd)
    );

    yaz0d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_lane     (lane),
        .out_count    (byte_count),
        .out_status   (out_status),
        .out_done     (stream_done),
        .out_run_last (run_last)
    );

    assign empty      = !out_valid;
    assign status     = out_status;
    assign out_byte_0 = lane[0];
    assign out_byte_1 = lane[1];
    assign out_byte_2 = lane[2];
    assign out_byte_3 = lane[3];
    assign out_byte_4 = lane[4];
    assign out_byte_5 = lane[5];
    assign out_byte_6 = lane[6];
    assign out_byte_7 = lane[7];

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> byte_count <= 4'd8)
        else $error("byte count above lane width");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && stream_done) |-> run_last)
        else $error("stream done on a beat that is not the last of its input");

    a_empty_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && byte_count == 4'd0) |-> (run_last && stream_done))
        else $error("empty beat that does not end the stream");

    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !cmd_push)
        else $error("command pushed into full queue");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for yaz0_stream_decompressor_core: random and directed yaz0 files
// are pushed in byte by byte and the output beats are checked against an in-bench model
// depends on yaz0d_pkg and the rtl of yaz0_stream_decompressor_core
module tb_top;
    import yaz0d_pkg::*;

    localparam int LIMIT   = 1000000;
    localparam int RUN_MAX = 280;

    typedef struct {
        logic [7:0] b;
        logic       last;
        bit         drain;
    } in_beat_t;

    typedef struct {
        logic [7:0] ob [8];
        logic [3:0] cnt;
        logic [1:0] st;
        logic       done;
        logic       rl;
    } out_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       pop = 1'b0;
    logic       full, empty, stream_done, run_last;
    logic [7:0] out_byte_0, out_byte_1, out_byte_2, out_byte_3;
    logic [7:0] out_byte_4, out_byte_5, out_byte_6, out_byte_7;
    logic [3:0] byte_count;
    logic [1:0] status;

    in_beat_t  file_bytes [$];
    out_beat_t due_beats [$];
    int        errors = 0;
    int        n_acc = 0;
    int        n_out = 0;
    int        n_files = 0;
    int        cycles = 0;
    int        tx_gap = 0;
    int        rx_gap = 0;
    int        rx_hold = 0;
    bit        rx_hold_done = 0;

    // decompressor state as the bench sees it
    logic [7:0]  hist [4096];
    logic [11:0] hp;
    int unsigned produced, target, hdr_idx, flags, flags_left, phase;
    logic [7:0]  first_b;
    logic [11:0] pend_dist;
    bit          passthru;
    logic [7:0]  run_buf [RUN_MAX];
    int          run_len;
    bit          dist_err;

    yaz0_stream_decompressor_core DUT (.*);

    always #4 clk = ~clk;

    function automatic logic [7:0] magic_at(int i);
        logic [7:0] m [4];
        m = '{8'h59, 8'h61, 8'h7A, 8'h30};
        return m[i];
    endfunction

    task automatic clear_stream();
        hp = '0; produced = 0; target = 0; hdr_idx = 0; flags = 0;
        flags_left = 0; phase = 0; first_b = '0; pend_dist = '0; passthru = 0;
    endtask

    task automatic put_raw(logic [7:0] v);
        if (run_len < RUN_MAX) begin
            run_buf[run_len] = v;
            run_len++;
        end
    endtask

    task automatic emit_byte(logic [7:0] v);
        put_raw(v);
        hist[hp] = v;
        hp = hp + 12'd1;
        produced++;
    endtask

    task automatic copy_back(int unsigned distance, int unsigned len);
        logic [7:0] v;
        for (int unsigned i = 0; i < len && produced < target; i++) begin
            if (produced < distance + 1) begin
                v = 8'h00;
                dist_err = 1;
            end else begin
                v = hist[12'(hp - distance - 1)];
            end
            emit_byte(v);
        end
    endtask

    task automatic next_flag();
        flags = (flags << 1) & 8'hFF;
        if (flags_left > 0) flags_left--;
        phase = 0;
    endtask

    // works out the output beats that one accepted input byte causes
    task automatic decode_byte(logic [7:0] b, logic last);
        bit          ended;
        status_t     st;
        int          nres, cnt;
        int unsigned d;
        out_beat_t   o;
        ended = 0;
        st = ST_OK;
        run_len = 0;
        dist_err = 0;
        if (passthru) begin
            put_raw(b);
            st = ST_PASSTHROUGH;
            ended = last;
        end else if (hdr_idx < HEADER_LEN) begin
            if (hdr_idx < 4) begin
                if (b != magic_at(hdr_idx)) begin
                    for (int j = 0; j < hdr_idx; j++) put_raw(magic_at(j));
                    put_raw(b);
                    passthru = 1;
                    st = ST_PASSTHROUGH;
                    ended = last;
                end else begin
                    hdr_idx++;
                    if (last) begin
                        if (hdr_idx < 4) begin
                            for (int j = 0; j < hdr_idx; j++) put_raw(magic_at(j));
                            st = ST_PASSTHROUGH;
                        end else begin
                            st = ST_TRUNCATED;
                        end
                        ended = 1;
                    end
                end
            end else begin
                if (hdr_idx < 8) target = (target << 8) | b;
                hdr_idx++;
                if (hdr_idx == HEADER_LEN && target == 0) begin
                    ended = 1;
                end else if (last) begin
                    ended = 1;
                    st = ST_TRUNCATED;
                end
            end
        end else if (produced >= target) begin
            if (last) clear_stream();
            return;
        end else begin
            if (phase == 0 && flags_left == 0) begin
                flags = b;
                flags_left = 8;
            end else if (phase == 0) begin
                if (flags & 8'h80) begin
                    emit_byte(b);
                    next_flag();
                end else begin
                    first_b = b;
                    phase = 1;
                end
            end else if (phase == 1) begin
                d = {first_b[3:0], b};
                if (first_b[7:4] != 0) begin
                    copy_back(d, first_b[7:4] + 2);
                    next_flag();
                end else begin
                    pend_dist = d[11:0];
                    phase = 2;
                end
            end else begin
                copy_back(pend_dist, 32'(b) + 32'h12);
                next_flag();
            end
            if (produced >= target) begin
                ended = 1;
            end else if (last) begin
                ended = 1;
                st = ST_TRUNCATED;
            end
            if (dist_err) st = ST_DIST_ERROR;
        end
        if (last) clear_stream();
        if (run_len == 0 && !ended) return;
        nres = (run_len == 0) ? 1 : (run_len + LANE_BYTES - 1) / LANE_BYTES;
        for (int k = 0; k < nres; k++) begin
            cnt = run_len - k * LANE_BYTES;
            if (cnt < 0) cnt = 0;
            if (cnt > LANE_BYTES) cnt = LANE_BYTES;
            for (int j = 0; j < 8; j++) o.ob[j] = (j < cnt) ? run_buf[k * LANE_BYTES + j] : 8'h00;
            o.cnt = 4'(cnt);
            o.st = st;
            o.done = (k + 1 == nres) && ended;
            o.rl = (k + 1 == nres);
            due_beats.push_back(o);
        end
    endtask

    task automatic queue_file(ref logic [7:0] f [$], input bit drain);
        in_beat_t t;
        for (int i = 0; i < f.size(); i++) begin
            t.b = f[i];
            t.last = (i == f.size() - 1);
            t.drain = drain && (i == 0);
            file_bytes.push_back(t);
        end
        n_files++;
    endtask

    task automatic add_header(ref logic [7:0] f [$], input int unsigned size);
        for (int i = 0; i < 4; i++) f.push_back(magic_at(i));
        for (int i = 3; i >= 0; i--) f.push_back(8'(size >> (8 * i)));
        for (int i = 0; i < 8; i++) f.push_back(8'($urandom));
    endtask

    // well-formed file with random tokens; bad distances, overrun and truncation on request
    task automatic gen_file(int unsigned size, int bad_dist_pct, int long_pct,
                            bit overrun, int cut, bit drain);
        logic [7:0]  f [$];
        int unsigned prod, goal, bdist, len, lim;
        int          tok, fidx;
        add_header(f, size);
        prod = 0;
        tok = 0;
        fidx = 0;
        goal = overrun ? size + 6 : size;
        while (prod < goal) begin
            if (tok % 8 == 0) begin
                fidx = f.size();
                f.push_back(8'h00);
            end
            if (prod == 0 || $urandom_range(0, 1)) begin
                f[fidx] = f[fidx] | (8'h80 >> (tok % 8));
                f.push_back(8'($urandom));
                prod++;
            end else begin
                lim = (prod - 1 > 4095) ? 4095 : prod - 1;
                bdist = ($urandom_range(0, 99) < bad_dist_pct) ? $urandom_range(0, 4095)
                                                               : $urandom_range(0, lim);
                if ($urandom_range(0, 99) < long_pct) begin
                    len = $urandom_range(18, 273);
                    f.push_back({4'h0, 4'(bdist >> 8)});
                    f.push_back(8'(bdist));
                    f.push_back(8'(len - 18));
                end else begin
                    len = $urandom_range(3, 17);
                    f.push_back({4'(len - 2), 4'(bdist >> 8)});
                    f.push_back(8'(bdist));
                end
                prod += len;
            end
            tok++;
        end
        if (cut > 0 && cut < f.size()) f = f[0:cut-1];
        queue_file(f, drain);
    endtask

    task automatic gen_bad_magic(int good, int extra);
        logic [7:0] f [$];
        logic [7:0] v;
        for (int i = 0; i < good; i++) f.push_back(magic_at(i));
        do v = 8'($urandom); while (v == magic_at(good));
        f.push_back(v);
        for (int i = 0; i < extra; i++) f.push_back(8'($urandom));
        queue_file(f, 0);
    endtask

    task automatic gen_prefix(int n, int unsigned size);
        logic [7:0] f [$];
        logic [7:0] h [$];
        add_header(h, size);
        for (int i = 0; i < n; i++) f.push_back(h[i]);
        queue_file(f, 0);
    endtask

    // sender side
    always @(posedge clk) begin
        in_beat_t t;
        logic     nxt;
        nxt = push;
        if (rst_n) begin
            if (push && !full) begin
                decode_byte(in_byte, in_last);
                n_acc++;
                nxt = 0;
                case ($urandom_range(0, 19))
                    0:       tx_gap = $urandom_range(10, 40);
                    1, 2, 3: tx_gap = $urandom_range(1, 3);
                    default: tx_gap = 0;
                endcase
            end
            if (!nxt) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (file_bytes.size() > 0 &&
                             (!file_bytes[0].drain || due_beats.size() == 0)) begin
                    t = file_bytes.pop_front();
                    in_byte <= t.b;
                    in_last <= t.last;
                    nxt = 1;
                end
            end
        end
        push <= nxt;
    end

    // long receiver hold-off once, so the command queue fills and input backs up
    always @(posedge clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else if (!rx_hold_done && n_acc >= 40) begin
            rx_hold <= 600;
            rx_hold_done <= 1;
        end
    end

    // receiver side
    always @(posedge clk) begin
        out_beat_t g, e;
        logic      nxt;
        nxt = 0;
        if (rst_n) begin
            if (pop && !empty) begin
                g.ob = '{out_byte_0, out_byte_1, out_byte_2, out_byte_3,
                         out_byte_4, out_byte_5, out_byte_6, out_byte_7};
                g.cnt = byte_count;
                g.st = status;
                g.done = stream_done;
                g.rl = run_last;
                n_out++;
                if (due_beats.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected output beat cnt=%0d", g.cnt);
                end else begin
                    e = due_beats.pop_front();
                    if (g.ob != e.ob || g.cnt !== e.cnt || g.st !== e.st ||
                        g.done !== e.done || g.rl !== e.rl) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch beat %0d: exp %h %h %h %h %h %h %h %h c%0d s%0d d%0d r%0d, got %h %h %h %h %h %h %h %h c%0d s%0d d%0d r%0d",
                                n_out, e.ob[0], e.ob[1], e.ob[2], e.ob[3], e.ob[4], e.ob[5],
                                e.ob[6], e.ob[7], e.cnt, e.st, e.done, e.rl,
                                g.ob[0], g.ob[1], g.ob[2], g.ob[3], g.ob[4], g.ob[5],
                                g.ob[6], g.ob[7], g.cnt, g.st, g.done, g.rl);
                    end
                end
            end
            if (rx_hold == 0) begin
                if (rx_gap > 0) begin
                    rx_gap--;
                end else begin
                    nxt = 1;
                    case ($urandom_range(0, 19))
                        0:       rx_gap = $urandom_range(10, 40);
                        1, 2, 3: rx_gap = $urandom_range(1, 3);
                        default: rx_gap = 0;
                    endcase
                end
            end
        end
        pop <= nxt;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 4096; i++) hist[i] = 8'h00;
        clear_stream();
        // directed files
        gen_file(5, 0, 0, 0, 0, 0);
        gen_file(1, 0, 0, 0, 0, 0);
        gen_bad_magic(0, 2);
        gen_bad_magic(3, 1);
        gen_prefix(2, 10);
        gen_prefix(9, 10);
        gen_prefix(16, 0);
        gen_file(20, 100, 0, 0, 0, 1);
        gen_file(40, 0, 100, 1, 0, 0);
        gen_file(30, 0, 0, 0, 22, 0);
        // random files, mostly well formed, until about 180 input bytes are queued
        while (file_bytes.size() < 180) begin
            case ($urandom_range(0, 9))
                0:       gen_bad_magic($urandom_range(0, 3), $urandom_range(0, 6));
                1:       gen_prefix($urandom_range(1, 16), $urandom_range(0, 1) ? 0 : 12);
                default: gen_file(($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 40),
                                  5, 8, $urandom_range(0, 4) == 0,
                                  ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) : 0,
                                  $urandom_range(0, 9) == 0);
            endcase
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (file_bytes.size() == 0 && !push);
        wait (due_beats.size() == 0);
        repeat (1200) @(posedge clk);
        $display("ran %0d files, %0d input bytes, %0d output beats, incl. passthrough, truncation,",
                 n_files, n_acc, n_out);
        $display("bad distances, overrun, long matches and input backpressure; %0d errors",
                 errors + due_beats.size());
        if (errors == 0 && due_beats.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: yaz0_stream_decompressor_core.f
rtl/yaz0d_pkg.sv
rtl/yaz0d_front.sv
rtl/yaz0d_cmdq.sv
rtl/yaz0d_back.sv
rtl/yaz0_stream_decompressor_core.sv
test/tb_top.sv
